@@ rtl/core/quantized_linear_layer_macros.svh @@
// assertion macros used by the quantized linear layer module
`ifndef QUANTIZED_LINEAR_LAYER_MACROS_SVH
`define QUANTIZED_LINEAR_LAYER_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define QLL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked on clk, off during rst
`define QLL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/core/qll_pkg.sv @@
// types and constants of the quantized linear layer
package qll_pkg;

  localparam int INT8_LIMIT = 127;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    ACT_LOAD_WEIGHT = 2'd0,
    ACT_LOAD_SCALE  = 2'd1,
    ACT_ELEMENT     = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_INPUT_SCALE     = 3'd0,
    REG_INPUT_INV_SCALE = 3'd1,
    REG_IN_FEATURES     = 3'd2,
    REG_OUT_FEATURES    = 3'd3,
    REG_RELU_ENABLE     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic acc_en;
    logic shift_en;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ rtl/core/quantized_linear_layer.sv @@
// an accepted activation goes through the product, magnitude and int8 registers to the cells
// throughput: one input item per cycle; after the last activation of a row the input
// stalls until the transaction of the row's last result
// readout: after the row's last activation is quantized, one column per cycle unless the
// receiver stalls, paced by the single dequantization pipeline behind the cell chain
// reset clears accumulators, counters and registers; weight and scale stores are not cleared
module quantized_linear_layer
  import qll_pkg::*;
#(
  parameter int MAX_IN_FEATURES  = 256,
  parameter int MAX_OUT_FEATURES = 16,
  parameter int FRACTION_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // weight_row, weight_column, weight, column_scale, activation
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // feature_index, output_value
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_result
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

`include "quantized_linear_layer_macros.svh"

  localparam int RW  = (MAX_IN_FEATURES > 1) ? $clog2(MAX_IN_FEATURES) : 1;
  localparam int CLW = (MAX_OUT_FEATURES > 1) ? $clog2(MAX_OUT_FEATURES) : 1;
  localparam int ICW = $clog2(MAX_IN_FEATURES + 1) + 1;
  localparam int OCW = $clog2(MAX_OUT_FEATURES + 1) + 1;
  localparam logic [63:0] HALF_Q = 64'd1 << (2 * FRACTION_BITS - 1);
  localparam logic [63:0] HALF_F = 64'd1 << (FRACTION_BITS - 1);

  // input fields
  logic [7:0]         in_row;
  logic [3:0]         in_col;
  logic [7:0]         in_weight;
  logic [31:0]        in_scale;
  logic signed [31:0] in_act;

  assign in_row    = s_axis_tdata[7:0];
  assign in_col    = s_axis_tdata[11:8];
  assign in_weight = s_axis_tdata[19:12];
  assign in_scale  = s_axis_tdata[51:20];
  assign in_act    = s_axis_tdata[83:52];

  // configuration
  logic [30:0] act_scale;
  logic [30:0] input_inverse_scale;
  logic [8:0]  in_features;
  logic [4:0]  out_features;
  logic        apply_relu_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_scale           <= 31'd65536;
      input_inverse_scale <= 31'd65536;
      in_features         <= 9'd256;
      out_features        <= 5'd16;
      apply_relu_enable   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_SCALE:     act_scale           <= cfg_data[30:0];
        REG_INPUT_INV_SCALE: input_inverse_scale <= cfg_data[30:0];
        REG_IN_FEATURES:     in_features         <= cfg_data[8:0];
        REG_OUT_FEATURES:    out_features        <= cfg_data[4:0];
        REG_RELU_ENABLE:     apply_relu_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [ICW-1:0] nin;
  logic [OCW-1:0] nout;

  always_comb begin
    if (in_features == '0) begin
      nin = ICW'(1);
    end else if (32'(in_features) > MAX_IN_FEATURES) begin
      nin = ICW'(MAX_IN_FEATURES);
    end else begin
      nin = ICW'(in_features);
    end
    if (out_features == '0) begin
      nout = OCW'(1);
    end else if (32'(out_features) > MAX_OUT_FEATURES) begin
      nout = OCW'(MAX_OUT_FEATURES);
    end else begin
      nout = OCW'(out_features);
    end
  end

  // input transaction
  logic busy;
  logic accept;
  logic is_elem;
  logic row_end;
  logic [RW-1:0] counter;

  assign s_axis_tready = !busy;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_elem = accept && (s_axis_tuser == ACT_ELEMENT);
  assign row_end = (ICW'(counter) + ICW'(1)) >= nin;

  // weight and scale stores
  logic [MAX_OUT_FEATURES-1:0][7:0] wmem [MAX_IN_FEATURES];
  logic [31:0]                      smem [MAX_OUT_FEATURES];

  always_ff @(posedge clk) begin
    if (accept && (s_axis_tuser == ACT_LOAD_WEIGHT) &&
        (32'(in_row) < MAX_IN_FEATURES) && (32'(in_col) < MAX_OUT_FEATURES)) begin
      wmem[RW'(in_row)][CLW'(in_col)] <= in_weight;
    end
    if (accept && (s_axis_tuser == ACT_LOAD_SCALE) &&
        (32'(in_col) < MAX_OUT_FEATURES)) begin
      smem[CLW'(in_col)] <= in_scale;
    end
  end

  // activation quantization pipeline
  logic               v1, v2, v3;
  logic               last1, last2, last3;
  logic signed [63:0] p1;
  logic [RW-1:0]      row1;
  logic [63:0]        mag2;
  logic               neg2;
  logic [MAX_OUT_FEATURES-1:0][7:0] w2, w3;
  logic signed [7:0]  q3;
  logic [63:0]        r_q;
  logic [6:0]         q_mag;

  assign r_q   = (mag2 + HALF_Q) >> (2 * FRACTION_BITS);
  assign q_mag = (r_q > 64'(INT8_LIMIT)) ? 7'(INT8_LIMIT) : r_q[6:0];

  always_ff @(posedge clk) begin
    p1    <= $signed(in_act) * $signed({1'b0, act_scale});
    row1  <= counter;
    mag2  <= p1[63] ? -p1 : p1;
    neg2  <= p1[63];
    w2    <= wmem[row1];
    w3    <= w2;
    q3    <= neg2 ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    last2 <= last1;
    last3 <= last2;
    last1 <= row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      counter <= '0;
    end else begin
      v1 <= is_elem;
      v2 <= v1;
      v3 <= v2;
      if (is_elem) begin
        counter <= row_end ? '0 : counter + RW'(1);
      end
    end
  end

  // readout control
  logic           emit;
  logic [CLW-1:0] e_col;
  logic           e_last;
  logic           adv;
  logic           issue;
  cell_ctrl_t     cctrl;
  logic [31:0]    head;

  assign adv    = !m_axis_tvalid || m_axis_tready;
  assign issue  = emit && adv;
  assign e_last = (OCW'(e_col) + OCW'(1)) == nout;

  assign cctrl.acc_en   = v3;
  assign cctrl.shift_en = issue;
  assign cctrl.clear    = issue && e_last;

  qll_chain #(
    .N (MAX_OUT_FEATURES)
  ) u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cctrl),
    .q     (q3),
    .w_row (w3),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      emit  <= 1'b0;
      e_col <= '0;
    end else begin
      if (is_elem && row_end) begin
        busy <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
        busy <= 1'b0;
      end
      if (v3 && last3) begin
        emit  <= 1'b1;
        e_col <= '0;
      end else if (issue) begin
        e_col <= e_col + CLW'(1);
        if (e_last) begin
          emit <= 1'b0;
        end
      end
    end
  end

  // dequantization pipeline, one column per cycle unless the receiver stalls
  logic               va, vb, vc, vd;
  logic [CLW-1:0]     col_a, col_b, col_c, col_d;
  logic               lst_a, lst_b, lst_c, lst_d;
  logic [31:0]        acc_a;
  logic signed [63:0] comb_a;
  logic signed [63:0] plo_b;
  logic [31:0]        phi_b;
  logic [63:0]        p_c;
  logic [63:0]        mag_d;
  logic               neg_d;
  logic [63:0]        r_f;
  logic [31:0]        val_e;
  logic [3:0]         out_col;
  logic [31:0]        out_val;

  assign r_f = (mag_d + HALF_F) >> FRACTION_BITS;

  always_comb begin
    val_e = neg_d ? -r_f[31:0] : r_f[31:0];
    if (apply_relu_enable && val_e[31]) begin
      val_e = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_a  <= head;
      comb_a <= $signed(smem[e_col]) * $signed({1'b0, input_inverse_scale});
      col_a  <= e_col;
      lst_a  <= e_last;
      plo_b  <= $signed({1'b0, comb_a[31:0]}) * $signed(acc_a);
      phi_b  <= comb_a[63:32] * acc_a;
      col_b  <= col_a;
      lst_b  <= lst_a;
      p_c    <= plo_b + {phi_b, 32'd0};
      col_c  <= col_b;
      lst_c  <= lst_b;
      mag_d  <= p_c[63] ? -p_c : p_c;
      neg_d  <= p_c[63];
      col_d  <= col_c;
      lst_d  <= lst_c;
      out_val      <= val_e;
      out_col      <= 4'(col_d);
      m_axis_tlast <= lst_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va            <= 1'b0;
      vb            <= 1'b0;
      vc            <= 1'b0;
      vd            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      va            <= issue;
      vb            <= va;
      vc            <= vb;
      vd            <= vc;
      m_axis_tvalid <= vd;
    end
  end

  assign m_axis_tdata = {4'd0, out_val, out_col};

  `QLL_ASSERT_NOW(a_stall_in_readout, emit, !s_axis_tready)
  `QLL_ASSERT_NEXT(a_row_end_starts_readout, v3 && last3, emit && (e_col == '0))
  `QLL_ASSERT_NEXT(a_last_issue_stops, issue && e_last, !emit)
  `QLL_ASSERT_NOW(a_no_accumulate_in_shift, issue, !v3)
  `QLL_ASSERT_NEXT(a_last_result_frees, m_axis_tvalid && m_axis_tready && m_axis_tlast, !busy)

endmodule

@@ rtl/core/qll_cell.sv @@
// one column accumulator cell of the chain
module qll_cell
  import qll_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic signed [7:0]  q,
  input  logic signed [7:0]  w,
  input  logic [31:0]        acc_in,
  output logic [31:0]        acc
);

  logic signed [15:0] prod;

  assign prod = q * w;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.shift_en) begin
      acc <= acc_in;
    end else if (ctrl.acc_en) begin
      acc <= acc + {{16{prod[15]}}, prod};
    end
  end

endmodule

@@ rtl/core/qll_chain.sv @@
// row of accumulator cells, shifting toward cell zero during readout
module qll_chain
  import qll_pkg::*;
#(
  parameter int N = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  logic signed [7:0]     q,
  input  logic [N-1:0][7:0]     w_row,
  output logic [31:0]           head
);

  logic [31:0] accs [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [31:0] from_next;
    if (i == N - 1) begin : g_end
      assign from_next = '0;
    end else begin : g_mid
      assign from_next = accs[i+1];
    end
    qll_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .q      (q),
      .w      ($signed(w_row[i])),
      .acc_in (from_next),
      .acc    (accs[i])
    );
  end

  assign head = accs[0];

endmodule

@@ test/quantized_linear_layer_checker.sv @@
// result predictor and checker for the quantized linear layer
`timescale 1ns / 1ps
module quantized_linear_layer_checker
  import qll_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output int                    fail_count,
  output int                    pending_results
);
  localparam int MAX_IN = 256;
  localparam int MAX_OUT = 16;
  localparam int FRAC = 16;

  typedef struct packed {
    logic [3:0]  feature_index;
    logic [31:0] output_value;
    logic        last_result;
  } column_result_t;

  logic [7:0]  weights [MAX_IN*MAX_OUT];
  logic [31:0] col_scales [MAX_OUT];
  logic [31:0] col_sums [MAX_OUT];
  logic [8:0]  elem_count;
  logic [30:0] act_scale, dequant_scale;
  logic [8:0]  row_len;
  logic [4:0]  col_count;
  logic        relu_on;
  column_result_t expected_results[$];

  assign pending_results = expected_results.size();

  // symmetric rounding shift of a two's complement 64-bit value
  function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
    logic [63:0] mag, r;
    mag = v[63] ? -v : v;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -r : r;
  endfunction

  task automatic accumulate_element(logic [31:0] act);
    longint prod, qv;
    int q, nin, nout, r;
    logic [63:0] p, comb;
    logic [31:0] v;
    column_result_t res;
    nin = (row_len < 1) ? 1 : (row_len > MAX_IN ? MAX_IN : row_len);
    nout = (col_count < 1) ? 1 : (col_count > MAX_OUT ? MAX_OUT : col_count);
    prod = longint'($signed(act)) * longint'({1'b0, act_scale});
    qv = $signed(round_shift(prod, 2 * FRAC));
    q = (qv > INT8_LIMIT) ? INT8_LIMIT : (qv < -INT8_LIMIT ? -INT8_LIMIT : int'(qv));
    r = (elem_count >= MAX_IN) ? MAX_IN - 1 : elem_count;
    for (int c = 0; c < nout; c++)
      col_sums[c] += q * int'($signed(weights[r*MAX_OUT + c]));
    if (int'(elem_count) + 1 < nin) begin
      elem_count = elem_count + 9'd1;
      return;
    end
    for (int c = 0; c < nout; c++) begin
      comb = longint'($signed(col_scales[c])) * longint'({1'b0, dequant_scale});
      p = comb * {{32{col_sums[c][31]}}, col_sums[c]};
      v = 32'(round_shift(p, FRAC));
      if (relu_on && v[31]) v = '0;
      res.feature_index = 4'(c);
      res.output_value = v;
      res.last_result = (c + 1 == nout);
      expected_results.push_back(res);
    end
    foreach (col_sums[c]) col_sums[c] = '0;
    elem_count = '0;
  endtask

  always @(posedge clk) begin
    column_result_t got, exp_r;
    if (rst) begin
      foreach (col_sums[c]) col_sums[c] <= '0;
      elem_count <= '0;
      act_scale <= 31'd65536;
      dequant_scale <= 31'd65536;
      row_len <= 9'd256;
      col_count <= 5'd16;
      relu_on <= 1'b1;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_INPUT_SCALE:     act_scale = cfg_data[30:0];
          REG_INPUT_INV_SCALE: dequant_scale = cfg_data[30:0];
          REG_IN_FEATURES:     row_len = cfg_data[8:0];
          REG_OUT_FEATURES:    col_count = cfg_data[4:0];
          REG_RELU_ENABLE:     relu_on = cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tlast};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.feature_index !== exp_r.feature_index ||
              got.output_value !== exp_r.output_value ||
              got.last_result !== exp_r.last_result) begin
            $display("%0t: mismatch, expected col %0d val %h last %b, actual col %0d val %h last %b",
                     $time, exp_r.feature_index, exp_r.output_value, exp_r.last_result,
                     got.feature_index, got.output_value, got.last_result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          ACT_LOAD_WEIGHT:
            weights[s_axis_tdata[7:0]*MAX_OUT + s_axis_tdata[11:8]] = s_axis_tdata[19:12];
          ACT_LOAD_SCALE: col_scales[s_axis_tdata[11:8]] = s_axis_tdata[51:20];
          ACT_ELEMENT: accumulate_element(s_axis_tdata[83:52]);
          default: ;
        endcase
      end
    end
  end
endmodule

@@ test/tb_quantized_linear_layer.sv @@
// stimulus and verdict for the quantized linear layer
`timescale 1ns / 1ps
module tb_quantized_linear_layer;
  import qll_pkg::*;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending_results;
  int cycle_count;
  bit quiet_sink, hold_sink;
  bit [4:0] rows_out, row_len;

  quantized_linear_layer i_dut (.*);
  quantized_linear_layer_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_sink) m_axis_tready <= 0;
      else m_axis_tready <= quiet_sink || ($urandom_range(99) >= 18);
    end
  end

  task automatic send_item(action_t act, logic [7:0] row, logic [3:0] col,
                           logic [7:0] wv, logic [31:0] sc, logic [31:0] av, bit idle_ok);
    while (idle_ok && !quiet_sink && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tdata <= {4'b0, av, sc, wv, col, row};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic configure(int nin, int nout, bit relu, logic [30:0] sa, logic [30:0] sb);
    write_reg(REG_IN_FEATURES, nin);
    write_reg(REG_OUT_FEATURES, nout);
    write_reg(REG_RELU_ENABLE, {31'd0, relu});
    write_reg(REG_INPUT_SCALE, {1'b0, sa});
    write_reg(REG_INPUT_INV_SCALE, {1'b0, sb});
  endtask

  // every weight and scale a row can read is written first
  task automatic load_all(int nin, bit extreme);
    logic [7:0] w;
    for (int c = 0; c < 16; c++)
      send_item(ACT_LOAD_SCALE, 8'($urandom), 4'(c), 8'($urandom),
                extreme ? (c[0] ? 32'h8000_0000 : 32'h7fff_ffff)
                        : 32'($urandom_range(200000)), 32'd0, 1);
    for (int r = 0; r < nin; r++)
      for (int c = 0; c < 16; c++) begin
        w = extreme ? (c[0] ? 8'h80 : 8'h7f) : 8'($urandom);
        send_item(ACT_LOAD_WEIGHT, 8'(r), 4'(c), w, $urandom, $urandom, 1);
      end
  endtask

  task automatic send_row(int nin, bit extreme);
    logic [31:0] a;
    for (int i = 0; i < nin; i++) begin
      case ($urandom_range(3))
        0: a = extreme ? 32'h8000_0000 : $urandom;
        1: a = extreme ? 32'h7fff_ffff : $urandom;
        default: a = (32'($urandom_range(40)) << 16) ^ {32{1'($urandom_range(1))}};
      endcase
      if ($urandom_range(15) == 0)
        send_item(action_t'(2'd3), 8'($urandom), 4'($urandom), 8'($urandom),
                  $urandom, $urandom, 1);
      send_item(ACT_ELEMENT, 8'($urandom), 4'($urandom), 8'($urandom), $urandom, a, 1);
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_sink = 0;
    hold_sink = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of all fields, out-of-range row and column counts
    // rows 0 to 3 of every column are written here and stay valid afterwards
    configure(4, 16, 0, 31'h7fff_ffff, 31'h7fff_ffff);
    load_all(4, 1);
    send_row(4, 1);
    drain_results();
    configure(0, 0, 1, 0, 0);
    send_row(1, 1);
    drain_results();
    configure(300, 31, 1, 31'd65536, 31'd65536);
    drain_results();

    // receiver held off while rows keep coming
    configure(2, 16, 1, 31'd65536, 31'd1000);
    repeat (4)
      send_item(ACT_LOAD_SCALE, 8'($urandom), 4'($urandom), 8'($urandom),
                32'($urandom_range(200000)), $urandom, 1);
    repeat (8)
      send_item(ACT_LOAD_WEIGHT, 8'($urandom_range(1)), 4'($urandom), 8'($urandom),
                $urandom, $urandom, 1);
    hold_sink = 1;
    fork
      begin repeat (8) send_row(2, 0); end
      begin repeat (300) @(posedge clk); hold_sink = 0; end
    join
    drain_results();

    // random settings, with a quiet stretch in the middle
    for (int ph = 0; ph < 3; ph++) begin
      row_len = 5'($urandom_range(1, 4));
      configure(row_len, $urandom_range(1, 16), 1'($urandom_range(1)),
                31'($urandom_range(200000)), 31'($urandom_range(200000)));
      quiet_sink = (ph == 1);
      rows_out = 5'($urandom_range(2, 3));
      for (int k = 0; k < rows_out; k++) begin
        if ($urandom_range(3) == 0)
          send_item(ACT_LOAD_WEIGHT, 8'($urandom_range(row_len - 1)), 4'($urandom),
                    8'($urandom), $urandom, $urandom, 1);
        send_row(row_len, 0);
      end
      drain_results();
      quiet_sink = 0;
    end

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
